// ===== rtl/core/sti_pkg.sv =====
// Shared types and codes for the sorted table block.
// No dependencies; imported by the top level of the block.
`default_nettype none

package sti_pkg;

   localparam int ACTION_WIDTH    = 3;
   localparam int DATA_WIDTH      = 32;
   localparam int POS_WIDTH       = 6;
   localparam int COUNT_OUT_WIDTH = 7;
   localparam int STATUS_WIDTH    = 2;

   typedef logic [ACTION_WIDTH-1:0]       action_type;
   typedef logic signed [DATA_WIDTH-1:0]  data_type;
   typedef logic [POS_WIDTH-1:0]          pos_type;
   typedef logic [COUNT_OUT_WIDTH-1:0]    count_out_type;
   typedef logic [STATUS_WIDTH-1:0]       status_type;

   localparam action_type ACT_INSERT  = 3'd0;
   localparam action_type ACT_PREPEND = 3'd1;
   localparam action_type ACT_APPEND  = 3'd2;
   localparam action_type ACT_REMOVE  = 3'd3;
   localparam action_type ACT_READ    = 3'd4;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_DROP  = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_table_insert_remove.sv =====
// Sorted table: keeps up to DEPTH distinct signed values in ascending order in one RAM.
// Depends on sti_pkg and sti_ram.
//
// A user sends one request transfer (insert, prepend, append, remove or read) and gets
// exactly one response transfer with the read value, the entry count after the
// operation and a status. The block works on one request at a time; req_stall is high
// from the accepting edge until the response is placed in the output register, and a
// new request may be taken while that response still waits. The entries live in a
// single RAM with one write and one registered read port, and every entry that an
// operation moves costs one write on that port. The RAM needs no clearing pass:
// only entries below the count are ever read.
`default_nettype none

module sorted_table_insert_remove #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sti_pkg::action_type    req_action,
   input  wire sti_pkg::data_type      req_value,
   input  wire sti_pkg::pos_type       req_position,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sti_pkg::data_type           rsp_read_value,
   output sti_pkg::count_out_type      rsp_count,
   output sti_pkg::status_type         rsp_status
);

   import sti_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_TAIL   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_APPEND = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   typedef logic signed [VALUE_WIDTH-1:0] entry_type;

   // Control state.
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers of the current request.
   action_type    action_ff, action_in;
   entry_type     value_ff, value_in;
   entry_type     carry_ff, carry_in;
   logic          carrying_ff, carrying_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   status_type    status_ff, status_in;
   data_type      rdval_ff, rdval_in;

   // Output register.
   data_type      rsp_read_value_ff, rsp_read_value_in;
   count_out_type rsp_count_ff, rsp_count_in;
   status_type    rsp_status_ff, rsp_status_in;

   // RAM port signals.
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   entry_type     ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   entry_type     ram_rd_data;

   // Decoded request terms.
   entry_type     req_entry;
   logic          table_full;
   logic          table_empty;
   logic          pos_bad;
   logic          pos_last;
   logic          ptr_last;

   // The value is taken as a signed number of its low bits and fitted to the entry width.
   assign req_entry   = VALUE_WIDTH'(req_value);
   assign table_full  = (count_ff == CW'(DEPTH));
   assign table_empty = (count_ff == '0);
   assign pos_bad     = (CMPW'(req_position) >= CMPW'(count_ff));
   assign pos_last    = ((CMPW'(req_position) + CMPW'(1)) == CMPW'(count_ff));
   assign ptr_last    = (CW'(ptr_ff) == (count_ff - CW'(1)));

   sti_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The sequencer streams through the RAM with reads running one entry ahead of the
   // writes. An entry is always read before it is overwritten, and a write never hits
   // the address read in the same cycle, so no forwarding path is needed.
   //
   // Insert and prepend walk forward from entry 0. Until the insertion point is found
   // nothing is written; an equal entry drops the value there with the table intact.
   // From the insertion point on, each cycle writes the carried value into the slot
   // just read and carries the old entry on; the last carried entry lands at the old
   // count in the tail state. Remove walks forward from the entry after the removed
   // one and copies each entry one slot down.
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      action_in         = action_ff;
      value_in          = value_ff;
      carry_in          = carry_ff;
      carrying_in       = carrying_ff;
      ptr_in            = ptr_ff;
      status_in         = status_ff;
      rdval_in          = rdval_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_status_in     = rsp_status_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = ptr_ff;
      ram_wr_data       = carry_ff;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in   = req_action;
               value_in    = req_entry;
               carrying_in = 1'b0;
               ptr_in      = '0;
               status_in   = ST_DONE;
               rdval_in    = '0;
               state_in    = S_RESP;
               case (req_action)
                  ACT_INSERT, ACT_PREPEND, ACT_APPEND: begin
                     if (table_full) begin
                        status_in = ST_FULL;
                     end else if (table_empty) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = req_entry;
                        count_in    = count_ff + CW'(1);
                     end else if (req_action == ACT_APPEND) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(count_ff - CW'(1));
                        state_in    = S_APPEND;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  ACT_REMOVE: begin
                     if (pos_bad) begin
                        status_in = ST_RANGE;
                     end else if (pos_last) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(req_position) + AW'(1);
                        ptr_in      = AW'(req_position) + AW'(1);
                        state_in    = S_SHIFT;
                     end
                  end
                  ACT_READ: begin
                     if (pos_bad) begin
                        status_in = ST_RANGE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(req_position);
                        state_in    = S_READ;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_ff + AW'(1);
            ptr_in      = ptr_ff + AW'(1);
            if (carrying_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = carry_ff;
               carry_in    = ram_rd_data;
            end else if (ram_rd_data < value_ff) begin
               if (action_ff == ACT_PREPEND) begin
                  status_in = ST_DROP;
                  state_in  = S_RESP;
               end else begin
                  carry_in = value_ff;
               end
            end else if (ram_rd_data == value_ff) begin
               status_in = ST_DROP;
               state_in  = S_RESP;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = value_ff;
               carry_in    = ram_rd_data;
               carrying_in = 1'b1;
            end
            if (ptr_last && (state_in == S_SCAN)) begin
               ram_rd_en = 1'b0;
               state_in  = S_TAIL;
            end
         end

         S_TAIL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(count_ff);
            ram_wr_data = carry_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_RESP;
         end

         S_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff - AW'(1);
            ram_wr_data = ram_rd_data;
            if (ptr_last) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff + AW'(1);
               ptr_in      = ptr_ff + AW'(1);
            end
         end

         S_APPEND: begin
            if (value_ff > ram_rd_data) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(count_ff);
               ram_wr_data = value_ff;
               count_in    = count_ff + CW'(1);
            end else begin
               status_in = ST_DROP;
            end
            state_in = S_RESP;
         end

         S_READ: begin
            rdval_in = DATA_WIDTH'(ram_rd_data);
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = rdval_ff;
               rsp_count_in      = COUNT_OUT_WIDTH'(count_ff);
               rsp_status_in     = status_ff;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff         <= action_in;
      value_ff          <= value_in;
      carry_ff          <= carry_in;
      carrying_ff       <= carrying_in;
      ptr_ff            <= ptr_in;
      status_ff         <= status_in;
      rdval_ff          <= rdval_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   // The entry count never exceeds the table size.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above table size");

   // The count moves by at most one entry per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((count_ff == $past(count_ff)) ||
                         (count_ff == $past(count_ff) + CW'(1)) ||
                         (count_ff + CW'(1) == $past(count_ff))))
      else $error("entry count jumped");

   // The RAM is never written while the block is waiting to respond.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> !ram_wr_en)
      else $error("RAM write outside an operation");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");

   // A new response is only loaded out of the response state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) |-> (state_ff == S_RESP))
      else $error("response loaded outside response state");

endmodule

`default_nettype wire

// ===== rtl/core/sti_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module sti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== tb/sorted_table_insert_remove_checker.sv =====
// Checker for the sorted table: keeps a shadow copy of the table, predicts each response
// from the accepted requests and compares every response transfer field by field.
// Depends on sti_pkg for the port types and the action and status codes.
`timescale 1ns / 1ps

module sorted_table_insert_remove_checker #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  sti_pkg::action_type    req_action,
   input  sti_pkg::data_type      req_value,
   input  sti_pkg::pos_type       req_position,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  sti_pkg::data_type      rsp_read_value,
   input  sti_pkg::count_out_type rsp_count,
   input  sti_pkg::status_type    rsp_status,
   output int                     mismatch_count,
   output int                     responses_owed,
   output int                     shadow_count
);
   import sti_pkg::*;

   typedef struct packed {
      data_type      read_value;
      count_out_type count;
      status_type    status;
   } table_response_type;

   data_type           shadow_entries [DEPTH];
   int                 shadow_fill = 0;
   int                 errors = 0;
   table_response_type responses_due [$];

   function automatic void shadow_open_slot(input int at, input data_type val);
      for (int i = shadow_fill; i > at; i--)
         shadow_entries[i] = shadow_entries[i - 1];
      shadow_entries[at] = val;
      shadow_fill++;
   endfunction

   // Applies one request to the shadow table and returns the response it owes.
   function automatic table_response_type table_op_outcome(input action_type act,
                                                           input data_type val,
                                                           input pos_type pos);
      table_response_type res;
      int                 slot;
      res.read_value = '0;
      res.status     = ST_DONE;
      case (act)
         ACT_INSERT, ACT_PREPEND, ACT_APPEND: begin
            if (shadow_fill >= DEPTH) begin
               res.status = ST_FULL;
            end else if (shadow_fill == 0) begin
               shadow_open_slot(0, val);
            end else if (act == ACT_INSERT) begin
               slot = 0;
               while (slot < shadow_fill && shadow_entries[slot] < val)
                  slot++;
               if (slot < shadow_fill && shadow_entries[slot] == val)
                  res.status = ST_DROP;
               else
                  shadow_open_slot(slot, val);
            end else if (act == ACT_PREPEND) begin
               if (val < shadow_entries[0])
                  shadow_open_slot(0, val);
               else
                  res.status = ST_DROP;
            end else begin
               if (val > shadow_entries[shadow_fill - 1])
                  shadow_open_slot(shadow_fill, val);
               else
                  res.status = ST_DROP;
            end
         end
         ACT_REMOVE: begin
            if (int'(pos) >= shadow_fill) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = int'(pos); i + 1 < shadow_fill; i++)
                  shadow_entries[i] = shadow_entries[i + 1];
               shadow_fill--;
            end
         end
         ACT_READ: begin
            if (int'(pos) >= shadow_fill)
               res.status = ST_RANGE;
            else
               res.read_value = shadow_entries[pos];
         end
         default: ;
      endcase
      res.count = count_out_type'(shadow_fill);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      table_response_type due;
      if (reset) begin
         responses_due.delete();
         shadow_fill = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (responses_due.size() == 0) begin
               $error("response transfer with no request outstanding");
               errors++;
            end else begin
               due = responses_due.pop_front();
               if (rsp_read_value !== due.read_value) begin
                  $error("read_value: expected %0d, actual %0d", due.read_value,
                         rsp_read_value);
                  errors++;
               end
               if (rsp_count !== due.count) begin
                  $error("count: expected %0d, actual %0d", due.count, rsp_count);
                  errors++;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, actual %0d", due.status, rsp_status);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            responses_due = {responses_due,
                             table_op_outcome(req_action, req_value, req_position)};
      end
      mismatch_count <= errors;
      responses_owed <= responses_due.size();
      shadow_count   <= shadow_fill;
   end

endmodule

// ===== tb/sorted_table_insert_remove_tb.sv =====
// Top of the sorted table testbench: clock, reset, request and response traffic, verdict.
// Depends on sti_pkg, the sorted_table_insert_remove block and its checker module.
`timescale 1ns / 1ps

module sorted_table_insert_remove_tb;
   import sti_pkg::*;

   localparam int DEPTH         = 64;
   localparam int RANDOM_ITEMS  = 900;
   localparam int BLOCK_ITEMS   = 60;
   localparam int IDLE_PERCENT  = 29;
   localparam int QUIET_FIRST   = 150;
   localparam int QUIET_LAST    = 300;
   localparam int HOLD_AT       = 400;
   localparam int HOLD_CYCLES   = 500;
   localparam int DRAIN_AT      = 700;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 400000;

   // Action codes that the block treats as no-ops.
   localparam action_type ACT_UNUSED_LO = 3'd5;
   localparam action_type ACT_UNUSED_HI = 3'd7;

   localparam data_type VALUE_MIN = 32'sh8000_0000;
   localparam data_type VALUE_MAX = 32'sh7fff_ffff;

   typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   action_type    req_action = ACT_INSERT;
   data_type      req_value = '0;
   pos_type       req_position = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   data_type      rsp_read_value;
   count_out_type rsp_count;
   status_type    rsp_status;

   int  mismatch_count;
   int  responses_owed;
   int  shadow_count;
   int  sent_count = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  hold_taken = 1'b0;
   logic quiet_stretch;

   // While the quiet stretch lasts, neither side idles and the block runs flat out.
   assign quiet_stretch = (sent_count >= QUIET_FIRST) && (sent_count < QUIET_LAST);

   always #6 clock = ~clock;

   sorted_table_insert_remove #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (DATA_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

   sorted_table_insert_remove_checker #(
      .DEPTH (DEPTH)
   ) table_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .responses_owed (responses_owed),
      .shadow_count   (shadow_count)
   );

   // A run that hangs anywhere ends here with a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side. It stalls at random, except during the quiet stretch. Once the
   // request count passes HOLD_AT it holds the response channel off for a long run of
   // cycles, so that the finished response stays in the output register, the block
   // stops taking requests and the sender is left waiting with a request on offer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_taken && sent_count >= HOLD_AT) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (quiet_stretch) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Puts one request on the channel and waits for the edge that accepts it. The
   // valid stays high afterwards; the caller lowers it only when it idles.
   task automatic send_request(input action_type act, input data_type val,
                               input pos_type pos);
      req_valid    <= 1'b1;
      req_action   <= act;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Sends a request and then idles the request side for a random number of cycles,
   // so that gaps land on every stage of the block's multi-cycle work.
   task automatic offer_request(input action_type act, input data_type val,
                                input pos_type pos);
      send_request(act, val, pos);
      while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Value choice. Prepends and appends often use values near the ends of the range so
   // that they usually land, while the narrow pool around zero produces plenty of
   // duplicates and out-of-order drops.
   function automatic data_type random_value(input action_type act, input bit spread);
      int roll;
      roll = $urandom_range(0, 99);
      if (act == ACT_PREPEND && roll < 35)
         return VALUE_MIN + data_type'($urandom_range(0, 1000));
      if (act == ACT_APPEND && roll < 35)
         return VALUE_MAX - data_type'($urandom_range(0, 1000));
      roll = $urandom_range(0, 99);
      if (roll < (spread ? 30 : 60))
         return data_type'($urandom_range(0, 95)) - 48;
      if (roll < (spread ? 40 : 70)) begin
         case ($urandom_range(0, 3))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return -1;
            default: return 0;
         endcase
      end
      return data_type'($urandom());
   endfunction

   // One random request. The mode sets the mix of actions: filling drives the table up
   // to full and beyond, draining empties it, and the mixed mode keeps it churning.
   task automatic offer_random_request(input traffic_mode_type mode);
      int         roll;
      int         w_ins;
      int         w_pre;
      int         w_app;
      int         w_rem;
      int         w_rd;
      action_type act;
      pos_type    pos;
      case (mode)
         MODE_FILL: begin
            w_ins = 50; w_pre = 15; w_app = 20; w_rem = 3; w_rd = 10;
         end
         MODE_MIXED: begin
            w_ins = 30; w_pre = 12; w_app = 12; w_rem = 22; w_rd = 20;
         end
         default: begin
            w_ins = 10; w_pre = 4; w_app = 4; w_rem = 57; w_rd = 23;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < w_ins)
         act = ACT_INSERT;
      else if (roll < w_ins + w_pre)
         act = ACT_PREPEND;
      else if (roll < w_ins + w_pre + w_app)
         act = ACT_APPEND;
      else if (roll < w_ins + w_pre + w_app + w_rem)
         act = ACT_REMOVE;
      else if (roll < w_ins + w_pre + w_app + w_rem + w_rd)
         act = ACT_READ;
      else
         act = action_type'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      // Indexes mostly fall inside the current table; the rest may run past the end.
      if (shadow_count > 0 && $urandom_range(0, 99) < 85)
         pos = pos_type'($urandom_range(0, shadow_count - 1));
      else
         pos = pos_type'($urandom_range(0, 63));
      offer_request(act, random_value(act, mode == MODE_FILL), pos);
   endtask

   initial begin : stimulus
      traffic_mode_type mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, duplicates, the range extremes, out-of-order
      // prepends and appends, bad indexes and the unused action codes.
      offer_request(ACT_READ, 0, 0);
      offer_request(ACT_REMOVE, 0, 63);
      offer_request(ACT_PREPEND, 5, 0);
      offer_request(ACT_REMOVE, 0, 0);
      offer_request(ACT_APPEND, -5, 0);
      offer_request(ACT_REMOVE, 0, 0);
      offer_request(ACT_INSERT, 0, 0);
      offer_request(ACT_INSERT, 0, 0);
      offer_request(ACT_INSERT, VALUE_MAX, 0);
      offer_request(ACT_INSERT, VALUE_MIN, 0);
      offer_request(ACT_PREPEND, VALUE_MIN, 0);
      offer_request(ACT_APPEND, VALUE_MAX, 0);
      offer_request(ACT_PREPEND, -7, 0);
      offer_request(ACT_REMOVE, 0, 0);
      offer_request(ACT_PREPEND, -7, 0);
      offer_request(ACT_APPEND, 9, 0);
      offer_request(ACT_REMOVE, 0, 2);
      offer_request(ACT_APPEND, 9, 0);
      offer_request(ACT_INSERT, 4, 0);
      offer_request(ACT_READ, 0, 3);
      offer_request(ACT_READ, 0, 0);
      offer_request(ACT_READ, 0, 4);
      offer_request(ACT_REMOVE, 0, 63);
      offer_request(ACT_UNUSED_LO, VALUE_MAX, 63);
      offer_request(ACT_UNUSED_HI, VALUE_MIN, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Once in the run the sender stops and lets the block drain completely.
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (responses_owed != 0);
         end
         case ((n / BLOCK_ITEMS) % 5)
            0, 1:    mode = MODE_FILL;
            2:       mode = MODE_MIXED;
            default: mode = MODE_DRAIN;
         endcase
         offer_random_request(mode);
      end
      req_valid <= 1'b0;

      // Wait for the last response, then give the block time to show any stray one.
      do @(posedge clock); while (responses_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && responses_owed == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
